### src/cbs_pkg.sv
`timescale 1ns / 1ps

package cbs_pkg;

    typedef enum logic
    {
        REQ_WRITE  = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_e;

    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;
    localparam logic [2:0] FACE_COUNT = 3'd6;

    localparam int DIV_STAGES = 17;

    typedef struct packed
    {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } texel_t;

    // Item fields that ride along the pipeline next to the arithmetic.
    typedef struct packed
    {
        req_e        req_type;
        logic        zero;
        logic [2:0]  face;
        logic        u_neg;
        logic        v_neg;
        logic [7:0]  tex_x;
        logic [7:0]  tex_y;
        texel_t      texel;
    } side_t;

    typedef struct packed
    {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic        bad_dir;
    } result_t;

endpackage

### src/cbs_req_if.sv
`timescale 1ns / 1ps

interface cbs_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [2:0]         face;
    logic [7:0]         tex_x;
    logic [7:0]         tex_y;
    logic [15:0]        red_in;
    logic [15:0]        green_in;
    logic [15:0]        blue_in;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;

    modport source
    (
        output valid, req_type, face, tex_x, tex_y, red_in, green_in, blue_in,
               dir_x, dir_y, dir_z,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, face, tex_x, tex_y, red_in, green_in, blue_in,
               dir_x, dir_y, dir_z,
        output ready
    );
endinterface

### src/cbs_res_if.sv
`timescale 1ns / 1ps

interface cbs_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic        bad_dir;

    modport source
    (
        output valid, red_out, green_out, blue_out, bad_dir,
        input  ready
    );

    modport sink
    (
        input  valid, red_out, green_out, blue_out, bad_dir,
        output ready
    );
endinterface

### src/cbs_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// Requires mag <= div; gives trunc(mag * 2^16 / div) in 17 bits.
module cbs_div
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] mag,
    input  logic [15:0] div,
    output logic [16:0] quo
);
    import cbs_pkg::*;

    logic [16:0] rem_reg [0:DIV_STAGES-1];
    logic [16:0] quo_reg [0:DIV_STAGES-1];
    logic [15:0] div_reg [0:DIV_STAGES-1];

    logic        bit0;
    assign bit0 = (mag >= div);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= bit0 ? {1'b0, mag - div} : {1'b0, mag};
            quo_reg[0] <= {bit0, 16'd0};
            div_reg[0] <= div;
        end
    end

    for (genvar i = 1; i < DIV_STAGES; i++)
    begin : g_stage
        logic [16:0] shifted;
        logic        take;
        logic [16:0] rem_next;
        logic [16:0] quo_next;

        always_comb
        begin
            shifted  = {rem_reg[i-1][15:0], 1'b0};
            take     = (shifted >= {1'b0, div_reg[i-1]});
            rem_next = take ? shifted - {1'b0, div_reg[i-1]} : shifted;
            quo_next = quo_reg[i-1];
            quo_next[DIV_STAGES-1-i] = take;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                quo_reg[i] <= quo_next;
                div_reg[i] <= div_reg[i-1];
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];
endmodule

### src/cbs_bank.sv
`timescale 1ns / 1ps

// One texel bank: one write port, one registered read port.
module cbs_bank #(
    parameter int DEPTH = 98304,
    parameter int AW    = 17
)
(
    input  logic            clk,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output cbs_pkg::texel_t rd_data,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  cbs_pkg::texel_t wr_data
);
    import cbs_pkg::*;

    texel_t mem [0:DEPTH-1];
    texel_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### src/cbs_out_fifo.sv
`timescale 1ns / 1ps

// Two-entry result queue; full is a register output so it can gate the pipe.
module cbs_out_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cbs_pkg::result_t push_data,
    output logic             full,
    cbs_res_if.source        res
);
    import cbs_pkg::*;

    result_t     slot_reg [0:1];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;
    result_t     head;

    assign pop  = res.valid && res.ready;
    assign full = (count_reg == 2'd2);
    assign head = slot_reg[rd_ptr_reg];

    assign res.valid     = (count_reg != 2'd0);
    assign res.red_out   = head.red_out;
    assign res.green_out = head.green_out;
    assign res.blue_out  = head.blue_out;
    assign res.bad_dir   = head.bad_dir;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

### src/cubemap_bilinear_sampler_top.sv
`timescale 1ns / 1ps

// Cubemap bilinear sampler. Takes one item per clock on req: a texel write
// (req_type 0) or a direction sample (req_type 1); each sample gives one
// transfer on res, writes give none. Throughput is one item per cycle as
// long as res drains; the pipe holds only when the two-entry result queue
// is full. A sample reaches res.valid through these registers in order: the
// face-choice register, loaded at the accepting edge, then 17 stages of the
// two pipelined restoring dividers (one per face axis), one for the
// coordinate multiply, one for index clamp and bank address, one for the
// registered bank read, one for the horizontal blend, one for the result
// queue. The texel store is split into four banks by x and y parity, so
// the four bilinear taps come out of one bank read. Writes pass through
// the same pipe and hit the banks at the read stage, so a sample sees every
// write accepted before it. The store is not cleared at reset: sample only
// texels that were written. The edge-length register may be written only
// while the block is idle.
module cubemap_bilinear_sampler_top #(
    parameter int MAX_FACE = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [8:0] cfg_wdata,
    cbs_req_if.sink    req,
    cbs_res_if.source  res
);
    import cbs_pkg::*;

    localparam int SW    = $clog2(MAX_FACE + 1);               // size width
    localparam int XW    = (MAX_FACE > 1) ? $clog2(MAX_FACE) : 1; // index width
    localparam int PW    = 16 + SW;                            // texel position
    localparam int HALF  = (MAX_FACE + 1) / 2;
    localparam int DEPTH = 6 * HALF * HALF;                    // per bank
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ---------------- configuration ----------------
    logic [8:0]    edge_len_reg;
    logic [SW-1:0] size_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_len_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            edge_len_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (edge_len_reg == 9'd0)
        begin
            size_eff = SW'(1);
        end
        else if (32'(edge_len_reg) > 32'(MAX_FACE))
        begin
            size_eff = SW'(MAX_FACE);
        end
        else
        begin
            size_eff = SW'(edge_len_reg);
        end
    end

    // ---------------- global advance ----------------
    logic q_full;
    logic en;

    assign en        = !q_full;
    assign req.ready = en;

    // ---------------- stage 1: face choice ----------------
    logic [15:0] ax, ay, az;
    logic        sx, sy, sz;
    side_t       s1_side;
    logic [15:0] s1_major, s1_mag_u, s1_mag_v;

    always_comb
    begin
        sx = req.dir_x[15];
        sy = req.dir_y[15];
        sz = req.dir_z[15];
        ax = sx ? 16'(-req.dir_x) : 16'(req.dir_x);
        ay = sy ? 16'(-req.dir_y) : 16'(req.dir_y);
        az = sz ? 16'(-req.dir_z) : 16'(req.dir_z);

        s1_side.req_type = req_e'(req.req_type);
        s1_side.zero     = (ax == 16'd0) && (ay == 16'd0) && (az == 16'd0);
        s1_side.tex_x    = req.tex_x;
        s1_side.tex_y    = req.tex_y;
        s1_side.texel    = '{red: req.red_in, green: req.green_in, blue: req.blue_in};

        if ((ax >= ay) && (ax >= az))
        begin
            s1_major = ax;
            s1_mag_u = az;
            s1_mag_v = ay;
            s1_side.v_neg = !sy;
            if (!sx)
            begin
                s1_side.face  = FACE_PX;
                s1_side.u_neg = !sz;
            end
            else
            begin
                s1_side.face  = FACE_NX;
                s1_side.u_neg = sz;
            end
        end
        else if (ay >= az)
        begin
            s1_major = ay;
            s1_mag_u = ax;
            s1_mag_v = az;
            s1_side.u_neg = sx;
            if (!sy)
            begin
                s1_side.face  = FACE_PY;
                s1_side.v_neg = sz;
            end
            else
            begin
                s1_side.face  = FACE_NY;
                s1_side.v_neg = !sz;
            end
        end
        else
        begin
            s1_major = az;
            s1_mag_u = ax;
            s1_mag_v = ay;
            s1_side.v_neg = !sy;
            if (!sz)
            begin
                s1_side.face  = FACE_PZ;
                s1_side.u_neg = sx;
            end
            else
            begin
                s1_side.face  = FACE_NZ;
                s1_side.u_neg = !sx;
            end
        end

        // a write keeps its own face code
        if (s1_side.req_type == REQ_WRITE)
        begin
            s1_side.face = req.face;
        end
    end

    logic        s1_vld_reg;
    side_t       s1_side_reg;
    logic [15:0] s1_major_reg, s1_mag_u_reg, s1_mag_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg  <= s1_side;
            s1_major_reg <= s1_major;
            s1_mag_u_reg <= s1_mag_u;
            s1_mag_v_reg <= s1_mag_v;
        end
    end

    // ---------------- divider stages ----------------
    logic [16:0] quo_u, quo_v;

    cbs_div u_div_u
    (
        .clk (clk),
        .en  (en),
        .mag (s1_mag_u_reg),
        .div (s1_major_reg),
        .quo (quo_u)
    );

    cbs_div u_div_v
    (
        .clk (clk),
        .en  (en),
        .mag (s1_mag_v_reg),
        .div (s1_major_reg),
        .quo (quo_v)
    );

    logic  dv_vld_reg  [0:DIV_STAGES-1];
    side_t dv_side_reg [0:DIV_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                dv_vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            dv_vld_reg[0] <= s1_vld_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                dv_vld_reg[i] <= dv_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= s1_side_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                dv_side_reg[i] <= dv_side_reg[i-1];
            end
        end
    end

    // ---------------- stage P: face coordinate and texel position ----------------
    side_t       dv_side;
    logic [17:0] u_sum, v_sum;
    logic [16:0] u_coord, v_coord;
    logic [PW-1:0] pu, pv;

    assign dv_side = dv_side_reg[DIV_STAGES-1];

    always_comb
    begin
        u_sum   = dv_side.u_neg ? 18'h10000 - {1'b0, quo_u} : 18'h10000 + {1'b0, quo_u};
        v_sum   = dv_side.v_neg ? 18'h10000 - {1'b0, quo_v} : 18'h10000 + {1'b0, quo_v};
        u_coord = u_sum[17:1];
        v_coord = v_sum[17:1];
        pu      = PW'(u_coord) * PW'(size_eff) + PW'(32768);
        pv      = PW'(v_coord) * PW'(size_eff) + PW'(32768);
    end

    logic          p_vld_reg;
    side_t         p_side_reg;
    logic [PW-1:0] pu_reg, pv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg <= dv_vld_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_side_reg <= dv_side;
            pu_reg     <= pu;
            pv_reg     <= pv;
        end
    end

    // ---------------- stage A: clamp indices ----------------
    // Position top bits h lie in [0, size]; taps are h-1 and h, clamped.
    logic [SW-1:0] hu, hv;
    logic [XW-1:0] x0, x1, y0, y1;

    always_comb
    begin
        hu = pu_reg[PW-1:16];
        hv = pv_reg[PW-1:16];
        x0 = (hu == '0) ? '0 : XW'(hu - SW'(1));
        x1 = (hu == size_eff) ? XW'(size_eff - SW'(1)) : XW'(hu);
        y0 = (hv == '0) ? '0 : XW'(hv - SW'(1));
        y1 = (hv == size_eff) ? XW'(size_eff - SW'(1)) : XW'(hv);
    end

    logic          a_vld_reg;
    side_t         a_side_reg;
    logic [XW-1:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [7:0]    tx_a_reg, ty_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg <= p_side_reg;
            x0_reg     <= x0;
            x1_reg     <= x1;
            y0_reg     <= y0;
            y1_reg     <= y1;
            tx_a_reg   <= pu_reg[15:8];
            ty_a_reg   <= pv_reg[15:8];
        end
    end

    // ---------------- banks: read for samples, write for texel writes ----------------
    logic          wr_ok;
    logic [31:0]   wr_lin;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_bank;
    texel_t        bank_q [0:3];

    always_comb
    begin
        wr_ok   = a_vld_reg && (a_side_reg.req_type == REQ_WRITE)
                  && (a_side_reg.face < FACE_COUNT)
                  && (32'(a_side_reg.tex_x) < 32'(MAX_FACE))
                  && (32'(a_side_reg.tex_y) < 32'(MAX_FACE));
        wr_bank = {a_side_reg.tex_y[0], a_side_reg.tex_x[0]};
        wr_lin  = (32'(a_side_reg.face) * 32'(HALF) + 32'(a_side_reg.tex_y[7:1]))
                  * 32'(HALF) + 32'(a_side_reg.tex_x[7:1]);
        wr_addr = wr_lin[AW-1:0];
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic [1:0] BSEL = 2'(b);

        logic [XW-1:0] bx_idx, by_idx;
        logic [31:0]   rd_lin;
        logic [AW-1:0] rd_addr;

        always_comb
        begin
            bx_idx  = (x0_reg[0] == BSEL[0]) ? x0_reg : x1_reg;
            by_idx  = (y0_reg[0] == BSEL[1]) ? y0_reg : y1_reg;
            rd_lin  = (32'(a_side_reg.face) * 32'(HALF) + (32'(by_idx) >> 1))
                      * 32'(HALF) + (32'(bx_idx) >> 1);
            rd_addr = rd_lin[AW-1:0];
        end

        cbs_bank #(
            .DEPTH (DEPTH),
            .AW    (AW)
        ) u_bank
        (
            .clk     (clk),
            .rd_en   (en),
            .rd_addr (rd_addr),
            .rd_data (bank_q[b]),
            .wr_en   (en && wr_ok && (wr_bank == BSEL)),
            .wr_addr (wr_addr),
            .wr_data (a_side_reg.texel)
        );
    end

    // ---------------- stage B: bank data arrives ----------------
    logic       b_vld_reg;
    side_t      b_side_reg;
    logic       xp0_reg, xp1_reg, yp0_reg, yp1_reg;
    logic [7:0] tx_b_reg, ty_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_side_reg <= a_side_reg;
            xp0_reg    <= x0_reg[0];
            xp1_reg    <= x1_reg[0];
            yp0_reg    <= y0_reg[0];
            yp1_reg    <= y1_reg[0];
            tx_b_reg   <= tx_a_reg;
            ty_b_reg   <= ty_a_reg;
        end
    end

    texel_t      c00, c10, c01, c11;
    logic [8:0]  wx1, wx0;
    logic [23:0] r0_red, r0_green, r0_blue, r1_red, r1_green, r1_blue;

    always_comb
    begin
        c00 = bank_q[{yp0_reg, xp0_reg}];
        c10 = bank_q[{yp0_reg, xp1_reg}];
        c01 = bank_q[{yp1_reg, xp0_reg}];
        c11 = bank_q[{yp1_reg, xp1_reg}];
        wx1 = {1'b0, tx_b_reg};
        wx0 = 9'd256 - wx1;
        r0_red   = 24'(c00.red) * 24'(wx0)   + 24'(c10.red) * 24'(wx1);
        r0_green = 24'(c00.green) * 24'(wx0) + 24'(c10.green) * 24'(wx1);
        r0_blue  = 24'(c00.blue) * 24'(wx0)  + 24'(c10.blue) * 24'(wx1);
        r1_red   = 24'(c01.red) * 24'(wx0)   + 24'(c11.red) * 24'(wx1);
        r1_green = 24'(c01.green) * 24'(wx0) + 24'(c11.green) * 24'(wx1);
        r1_blue  = 24'(c01.blue) * 24'(wx0)  + 24'(c11.blue) * 24'(wx1);
    end

    // ---------------- stage C: horizontal blend registered ----------------
    logic        c_vld_reg;
    req_e        c_type_reg;
    logic        c_zero_reg;
    logic [7:0]  ty_c_reg;
    logic [23:0] r0_red_reg, r0_green_reg, r0_blue_reg;
    logic [23:0] r1_red_reg, r1_green_reg, r1_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_type_reg   <= b_side_reg.req_type;
            c_zero_reg   <= b_side_reg.zero;
            ty_c_reg     <= ty_b_reg;
            r0_red_reg   <= r0_red;
            r0_green_reg <= r0_green;
            r0_blue_reg  <= r0_blue;
            r1_red_reg   <= r1_red;
            r1_green_reg <= r1_green;
            r1_blue_reg  <= r1_blue;
        end
    end

    // vertical blend with round half up, straight into the result queue
    logic [8:0]  wy1, wy0;
    logic [32:0] s_red, s_green, s_blue;
    result_t     res_data;
    logic        push;

    always_comb
    begin
        wy1     = {1'b0, ty_c_reg};
        wy0     = 9'd256 - wy1;
        s_red   = 33'(r0_red_reg) * 33'(wy0)   + 33'(r1_red_reg) * 33'(wy1)   + 33'(32768);
        s_green = 33'(r0_green_reg) * 33'(wy0) + 33'(r1_green_reg) * 33'(wy1) + 33'(32768);
        s_blue  = 33'(r0_blue_reg) * 33'(wy0)  + 33'(r1_blue_reg) * 33'(wy1)  + 33'(32768);
        if (c_zero_reg)
        begin
            res_data = '{red_out: 16'd0, green_out: 16'd0, blue_out: 16'd0,
                         bad_dir: 1'b1};
        end
        else
        begin
            res_data = '{red_out: s_red[31:16], green_out: s_green[31:16],
                         blue_out: s_blue[31:16], bad_dir: 1'b0};
        end
        push = en && c_vld_reg && (c_type_reg == REQ_SAMPLE);
    end

    cbs_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res_data),
        .full      (q_full),
        .res       (res)
    );
endmodule

### tb/cubemap_bilinear_sampler_top_tb.sv
`timescale 1ns / 1ps

module cubemap_bilinear_sampler_top_tb;
    import cbs_pkg::*;

    localparam int MAX_FACE    = 256;
    localparam int LATENCY     = 22;
    localparam int CYCLE_LIMIT = 400000;

    // One request as the driver puts it on the bus.
    typedef struct {
        req_e               kind;
        logic [2:0]         face;
        logic [7:0]         tex_x;
        logic [7:0]         tex_y;
        logic [15:0]        red;
        logic [15:0]        green;
        logic [15:0]        blue;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } request_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [8:0] cfg_wdata;

    cbs_req_if req ();
    cbs_res_if res ();

    cubemap_bilinear_sampler_top #(.MAX_FACE(MAX_FACE)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .res       (res.source)
    );

    // ------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------
    request_t    pending_reqs[$];     // filled by the stimulus block
    result_t     expected_colors[$];  // one entry per accepted sample
    logic [47:0] texel_mem[int];      // predictor's copy of the texel store
    bit          planned_texels[int]; // texels that the stimulus has written
    int          active_size;         // effective face size seen by the predictor
    int          gen_size;            // face size the stimulus plans against
    int          fail_count = 0;
    int          cycle_count = 0;
    request_t    on_bus;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int clamp_size(input int s);
        if (s < 1)
            return 1;
        if (s > MAX_FACE)
            return MAX_FACE;
        return s;
    endfunction

    function automatic int texel_addr(input int f, input int x, input int y);
        return (f * MAX_FACE + y) * MAX_FACE + x;
    endfunction

    // Q1.16 face coordinate from a signed minor component and the major magnitude.
    function automatic int face_coord(input int n, input int m);
        int mag;
        int q;
        mag = (n < 0) ? -n : n;
        q   = int'((longint'(mag) << 16) / longint'(m));
        return (n < 0) ? (65536 - q) >>> 1 : (65536 + q) >>> 1;
    endfunction

    function automatic int clamp_idx(input int i, input int sz);
        if (i < 0)
            return 0;
        if (i > sz - 1)
            return sz - 1;
        return i;
    endfunction

    // Face, the four clamped tap indices and the Q0.8 weights of a sample.
    function automatic void find_taps(input int dx, input int dy, input int dz,
                                      input int sz, output int f,
                                      output int x0, output int x1,
                                      output int y0, output int y1,
                                      output int tx, output int ty);
        int ax;
        int ay;
        int az;
        int u;
        int v;
        int px;
        int py;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        az = (dz < 0) ? -dz : dz;
        if (ax >= ay && ax >= az)
        begin
            f = (dx > 0) ? FACE_PX : FACE_NX;
            u = (dx > 0) ? face_coord(-dz, ax) : face_coord(dz, ax);
            v = face_coord(-dy, ax);
        end
        else if (ay >= az)
        begin
            f = (dy > 0) ? FACE_PY : FACE_NY;
            u = face_coord(dx, ay);
            v = face_coord((dy > 0) ? dz : -dz, ay);
        end
        else
        begin
            f = (dz > 0) ? FACE_PZ : FACE_NZ;
            u = (dz > 0) ? face_coord(dx, az) : face_coord(-dx, az);
            v = face_coord(-dy, az);
        end
        px = u * sz + 32768;
        py = v * sz + 32768;
        x0 = clamp_idx((px >>> 16) - 1, sz);
        x1 = clamp_idx(px >>> 16, sz);
        y0 = clamp_idx((py >>> 16) - 1, sz);
        y1 = clamp_idx(py >>> 16, sz);
        tx = (px >>> 8) & 255;
        ty = (py >>> 8) & 255;
    endfunction

    function automatic logic [47:0] read_texel(input int a);
        return texel_mem.exists(a) ? texel_mem[a] : 48'd0;
    endfunction

    // Filtered color of one sample against the predictor's store.
    function automatic result_t predict_color(input request_t r);
        result_t     c;
        int          f;
        int          x0;
        int          x1;
        int          y0;
        int          y1;
        int          tx;
        int          ty;
        logic [47:0] t00;
        logic [47:0] t10;
        logic [47:0] t01;
        logic [47:0] t11;
        longint      r0;
        longint      r1;
        longint      s;
        logic [15:0] chan[3];
        c = '0;
        if (r.dir_x == 0 && r.dir_y == 0 && r.dir_z == 0)
        begin
            c.bad_dir = 1'b1;
            return c;
        end
        find_taps(int'(r.dir_x), int'(r.dir_y), int'(r.dir_z), active_size,
                  f, x0, x1, y0, y1, tx, ty);
        t00 = read_texel(texel_addr(f, x0, y0));
        t10 = read_texel(texel_addr(f, x1, y0));
        t01 = read_texel(texel_addr(f, x0, y1));
        t11 = read_texel(texel_addr(f, x1, y1));
        for (int k = 0; k < 3; k++)
        begin
            r0 = longint'(t00[47-16*k -: 16]) * (256 - tx)
               + longint'(t10[47-16*k -: 16]) * tx;
            r1 = longint'(t01[47-16*k -: 16]) * (256 - tx)
               + longint'(t11[47-16*k -: 16]) * tx;
            s  = r0 * (256 - ty) + r1 * ty;
            chan[k] = 16'((s + 32768) >>> 16);
        end
        c.red_out   = chan[0];
        c.green_out = chan[1];
        c.blue_out  = chan[2];
        return c;
    endfunction

    // Write as the store sees it (faces 6 and 7 dropped); samples queue their color.
    function automatic void apply_request(input request_t r);
        if (r.kind == REQ_WRITE)
        begin
            if (r.face < FACE_COUNT)
                texel_mem[texel_addr(r.face, r.tex_x, r.tex_y)] = {r.red, r.green, r.blue};
        end
        else
            expected_colors.push_back(predict_color(r));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic request_t random_request();
        request_t r;
        r.kind  = req_e'($urandom_range(0, 1));
        r.face  = 3'($urandom);
        r.tex_x = 8'($urandom);
        r.tex_y = 8'($urandom);
        r.red   = 16'($urandom);
        r.green = 16'($urandom);
        r.blue  = 16'($urandom);
        r.dir_x = 16'($urandom);
        r.dir_y = 16'($urandom);
        r.dir_z = 16'($urandom);
        return r;
    endfunction

    function automatic logic [15:0] pick_color();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_write(input int f, input int x, input int y,
                               input logic [15:0] r, input logic [15:0] g,
                               input logic [15:0] b);
        request_t w;
        w       = random_request();
        w.kind  = REQ_WRITE;
        w.face  = 3'(f);
        w.tex_x = 8'(x);
        w.tex_y = 8'(y);
        w.red   = r;
        w.green = g;
        w.blue  = b;
        if (f < FACE_COUNT)
            planned_texels[texel_addr(f, x, y)] = 1'b1;
        pending_reqs.push_back(w);
    endtask

    // Queues writes for any of the four taps not yet planned, then queues the sample.
    task automatic queue_sample(input logic signed [15:0] dx,
                                input logic signed [15:0] dy,
                                input logic signed [15:0] dz);
        request_t s;
        int       f;
        int       xs[2];
        int       ys[2];
        int       tx;
        int       ty;
        s       = random_request();
        s.kind  = REQ_SAMPLE;
        s.dir_x = dx;
        s.dir_y = dy;
        s.dir_z = dz;
        if (dx != 0 || dy != 0 || dz != 0)
        begin
            find_taps(int'(dx), int'(dy), int'(dz), gen_size,
                      f, xs[0], xs[1], ys[0], ys[1], tx, ty);
            foreach (xs[i])
                foreach (ys[j])
                    if (!planned_texels.exists(texel_addr(f, xs[i], ys[j])))
                        queue_write(f, xs[i], ys[j], pick_color(), pick_color(),
                                    pick_color());
        end
        pending_reqs.push_back(s);
    endtask

    function automatic logic signed [15:0] pick_component(input logic signed [15:0] other);
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return other;
            4:       return -other;
            5:       return 16'($urandom_range(0, 16)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // Queues about count items, tap writes included.
    task automatic random_phase(input int count);
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        int                 target;
        target = pending_reqs.size() + count;
        while (pending_reqs.size() < target)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                // mostly valid faces, now and then one the store drops
                queue_write(($urandom_range(0, 9) == 0) ? $urandom_range(6, 7)
                                                        : $urandom_range(0, 5),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            pick_color(), pick_color(), pick_color());
            end
            else
            begin
                dx = pick_component(16'($urandom));
                dy = pick_component(dx);
                dz = pick_component(dy);
                if ($urandom_range(0, 39) == 0)
                begin
                    dx = 0;
                    dy = 0;
                    dz = 0;
                end
                queue_sample(dx, dy, dz);
            end
        end
    endtask

    task automatic directed_phase();
        // extreme colors and the edge coordinates, plus dropped writes
        queue_write(FACE_PX, 0, 0, 16'h0000, 16'hFFFF, 16'h0000);
        queue_write(FACE_PX, 255, 255, 16'hFFFF, 16'h0000, 16'hFFFF);
        queue_write(6, 3, 4, 16'h1234, 16'h5678, 16'h9ABC);
        queue_write(7, 255, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // zero direction gives black with the error flag
        queue_sample(0, 0, 0);
        // each face along its axis, then two cube corners
        queue_sample(16'sh7FFF, 0, 0);
        queue_sample(16'sh8000, 0, 0);
        queue_sample(0, 16'sh7FFF, 0);
        queue_sample(0, 16'sh8000, 0);
        queue_sample(0, 0, 16'sh7FFF);
        queue_sample(0, 0, 16'sh8000);
        queue_sample(16'sh7FFF, 16'sh7FFF, 16'sh8000);
        queue_sample(16'sh8000, 16'sh8000, 16'sh7FFF);
        // ties go x first, then y
        queue_sample(16'sd100, 16'sd100, 16'sd100);
        queue_sample(-16'sd100, 16'sd50, -16'sd100);
        queue_sample(16'sd3, -16'sd7, -16'sd7);
        queue_sample(16'sd1, 16'sd0, 16'sd0);
        queue_sample(-16'sd1, -16'sd1, 16'sd1);
        // overwrite a texel already in use, then read it back
        queue_write(FACE_PX, 127, 127, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_sample(16'sh7FFF, 16'sd0, 16'sd0);
    endtask

    // Waits for the pipe to drain, then writes the edge length.
    task automatic set_edge_len(input int s);
        while (pending_reqs.size() != 0 || req.valid || expected_colors.size() != 0)
            @(posedge clk);
        // writes leave no result behind, so give the pipe its latency to empty
        repeat (LATENCY + 6) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 9'(s);
        @(posedge clk);
        cfg_we      <= 1'b0;
        active_size  = clamp_size(s);
        gen_size     = clamp_size(s);
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid  <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            // an accepted transfer updates the predictor
            if (req.valid && req.ready)
                apply_request(on_bus);
            if (req.valid && !req.ready)
            begin
                // hold the item until the block takes it
            end
            else if (gap_left > 0)
            begin
                gap_left  <= gap_left - 1;
                req.valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                on_bus        = pending_reqs.pop_front();
                req.valid    <= 1'b1;
                req.req_type <= on_bus.kind;
                req.face     <= on_bus.face;
                req.tex_x    <= on_bus.tex_x;
                req.tex_y    <= on_bus.tex_y;
                req.red_in   <= on_bus.red;
                req.green_in <= on_bus.green;
                req.blue_in  <= on_bus.blue;
                req.dir_x    <= on_bus.dir_x;
                req.dir_y    <= on_bus.dir_y;
                req.dir_z    <= on_bus.dir_z;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and stall pattern
    // ------------------------------------------------------------------
    result_t want;
    int      stall_mode;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready  <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    $display("%0t: result transfer with none expected: %h %h %h %b", $time,
                             res.red_out, res.green_out, res.blue_out, res.bad_dir);
                    fail_count++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (res.red_out !== want.red_out)
                    begin
                        $display("%0t: red_out expected %h actual %h", $time,
                                 want.red_out, res.red_out);
                        fail_count++;
                    end
                    if (res.green_out !== want.green_out)
                    begin
                        $display("%0t: green_out expected %h actual %h", $time,
                                 want.green_out, res.green_out);
                        fail_count++;
                    end
                    if (res.blue_out !== want.blue_out)
                    begin
                        $display("%0t: blue_out expected %h actual %h", $time,
                                 want.blue_out, res.blue_out);
                        fail_count++;
                    end
                    if (res.bad_dir !== want.bad_dir)
                    begin
                        $display("%0t: bad_dir expected %b actual %b", $time,
                                 want.bad_dir, res.bad_dir);
                        fail_count++;
                    end
                end
            end
            // stall style is drawn at random from four ready patterns
            if (cycle_count % 256 == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0:       res.ready <= 1'b1;
                1:       res.ready <= (cycle_count % 8) < 3;
                2:       res.ready <= 1'($urandom_range(0, 1));
                default: res.ready <= (cycle_count % 32) >= 20;
            endcase
        end
    end

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    int size_list[10] = '{1, 2, 0, 3, 7, 16, 511, 300, 256, 64};

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        active_size = MAX_FACE;
        gen_size    = MAX_FACE;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset value of the edge length first
        directed_phase();
        random_phase(80);
        foreach (size_list[i])
        begin
            set_edge_len(size_list[i]);
            random_phase(90);
        end

        while (pending_reqs.size() != 0 || req.valid || expected_colors.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
